>>> hdl/set_assoc_flow_table_macros.svh
// assertion macros used by the flow table back end
`ifndef SET_ASSOC_FLOW_TABLE_MACROS_SVH
`define SET_ASSOC_FLOW_TABLE_MACROS_SVH

// same-cycle implication, checked out of reset
`define SFT_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define SFT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/sft_pkg.sv
// shared types, constants and helpers of the set-associative flow table
package sft_pkg;

  localparam int FLOW_SLOTS = 1024;
  localparam int SLOT_W     = 10;
  localparam int SET_WAYS   = 8;
  localparam int WAY_W      = 3;
  localparam int TIN_COUNT  = 4;
  localparam int TIN_W      = 2;
  localparam int BYTES_W    = 16;
  localparam int BL_W       = 32;
  localparam int Q_W        = 16;
  localparam int REF_W      = 11;
  localparam int SEED_W     = 32;
  localparam int S_TDATA_W  = 40;
  localparam int M_TDATA_W  = 96;
  localparam int PADDR_W    = 4;
  localparam int PDATA_W    = 32;

  localparam logic [31:0]      HOST_MIX      = 32'h045d_9f3b;
  localparam logic [Q_W-1:0]   QUANTUM_RESET = 16'd1514;
  localparam logic [REF_W-1:0] REF_MAX       = 11'd2047;

  localparam logic CMD_ENQ   = 1'b0;
  localparam logic CMD_DEBIT = 1'b1;

  localparam logic [1:0] ISO_NONE = 2'd0;
  localparam logic [1:0] ISO_SRC  = 2'd1;
  localparam logic [1:0] ISO_DST  = 2'd2;
  localparam logic [1:0] ISO_BOTH = 2'd3;

  localparam logic [1:0] REG_HASH_SEED    = 2'd0;
  localparam logic [1:0] REG_ISO_MODE     = 2'd1;
  localparam logic [1:0] REG_BASE_QUANTUM = 2'd2;

  typedef struct packed {
    logic [SEED_W-1:0] hash_seed;
    logic [1:0]        iso_mode;
    logic [Q_W-1:0]    base_quantum;
  } cfg_t;

  typedef struct packed {
    logic               cmd;
    logic [SLOT_W-1:0]  key;
    logic [TIN_W-1:0]   tin;
    logic [BYTES_W-1:0] bytes;
    logic [SLOT_W-1:0]  slot_in;
    logic [SLOT_W-1:0]  src_host;
    logic [SLOT_W-1:0]  dst_host;
  } job_t;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic              new_flow;
    logic              evicted;
    logic [Q_W-1:0]    start_deficit;
    logic              flow_empty;
    logic [BL_W-1:0]   flow_backlog;
    logic [BL_W-1:0]   tin_backlog;
  } result_t;

  typedef struct packed {
    logic              active;
    logic [SLOT_W-1:0] key;
    logic [BL_W-1:0]   backlog;
    logic [TIN_W-1:0]  tin;
    logic [SLOT_W-1:0] src_host;
    logic [SLOT_W-1:0] dst_host;
  } slot_rec_t;

  function automatic logic [31:0] host_fold(input logic [31:0] h);
    return h ^ (h >> 16);
  endfunction

  function automatic logic [SLOT_W-1:0] host_final(input logic [31:0] p);
    logic [31:0] h;
    h = p ^ (p >> 16);
    return h[SLOT_W-1:0];
  endfunction

  function automatic logic [BL_W-1:0] sat_add(input logic [BL_W-1:0] a,
                                               input logic [BYTES_W-1:0] b);
    logic [BL_W:0] s;
    s = {1'b0, a} + {{(BL_W-BYTES_W+1){1'b0}}, b};
    return s[BL_W] ? '1 : s[BL_W-1:0];
  endfunction

  function automatic logic [BL_W-1:0] sat_sub(input logic [BL_W-1:0] a,
                                               input logic [BYTES_W-1:0] b);
    logic [BL_W-1:0] bx;
    bx = {{(BL_W-BYTES_W){1'b0}}, b};
    return (a >= bx) ? a - bx : '0;
  endfunction

endpackage

>>> hdl/sft_front.sv
// front end: accepts items, clamps the tin and computes both host hashes
module sft_front #(
  parameter int TinCount = sft_pkg::TIN_COUNT
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // flow_hash[9:0], tin[11:10], pkt_bytes[27:12], slot_in[37:28], zero pad
  input  logic [sft_pkg::S_TDATA_W-1:0] s_axis_tdata,
  // cmd
  input  logic                         s_axis_tuser,
  input  logic [sft_pkg::SEED_W-1:0]   hash_seed_i,
  input  logic                         init_done_i,
  input  logic                         q_full_i,
  output logic                         q_push_o,
  output sft_pkg::job_t                q_data_o
);
  import sft_pkg::*;

  typedef enum logic [3:0] {
    F_IDLE = 4'b0001,
    F_SRC  = 4'b0010,
    F_DST  = 4'b0100,
    F_PUSH = 4'b1000
  } fstate_e;

  fstate_e           state_q, state_d;
  job_t              job_q;
  logic [31:0]       pre_src_q, pre_dst_q, prod_q;
  logic [31:0]       mul_in, mul_out, key_x;
  logic [TIN_W-1:0]  tin_in;
  logic              accept;

  assign s_axis_tready = init_done_i && (state_q == F_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign key_x         = {{(32-SLOT_W){1'b0}}, s_axis_tdata[SLOT_W-1:0]};
  assign tin_in        = (int'(s_axis_tdata[11:10]) >= TinCount) ? '0 : s_axis_tdata[11:10];
  assign mul_in        = (state_q == F_SRC) ? pre_src_q : pre_dst_q;
  assign mul_out       = mul_in * HOST_MIX;

  always_comb begin
    q_data_o          = job_q;
    q_data_o.dst_host = host_final(prod_q);
  end
  assign q_push_o = (state_q == F_PUSH) && !q_full_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      F_IDLE: if (accept) state_d = F_SRC;
      F_SRC:  state_d = F_DST;
      F_DST:  state_d = F_PUSH;
      F_PUSH: if (!q_full_i) state_d = F_IDLE;
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      job_q.cmd      <= s_axis_tuser;
      job_q.key      <= s_axis_tdata[SLOT_W-1:0];
      job_q.tin      <= tin_in;
      job_q.bytes    <= s_axis_tdata[27:12];
      job_q.slot_in  <= s_axis_tdata[37:28];
      job_q.src_host <= '0;
      job_q.dst_host <= '0;
      pre_src_q      <= host_fold(hash_seed_i ^ key_x);
      pre_dst_q      <= host_fold(hash_seed_i ^ ~key_x);
    end
    if (state_q == F_SRC || state_q == F_DST) begin
      prod_q <= mul_out;
    end
    if (state_q == F_DST) begin
      job_q.src_host <= host_final(prod_q);
    end
  end

endmodule

>>> hdl/sft_queue.sv
// two-entry queue of classified items between front and back
module sft_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  sft_pkg::job_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output sft_pkg::job_t data_o
);
  import sft_pkg::*;

  job_t       mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;

  assign full_o  = (count_q == 2'd2);
  assign empty_o = (count_q == 2'd0);
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i) rd_ptr_q <= ~rd_ptr_q;
      if (push_i && !pop_i) begin
        count_q <= count_q + 2'd1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= data_i;
  end

endmodule

>>> hdl/sft_back.sv
// back end: set scan, way update, host refcounts, quantum divide, result register
`include "set_assoc_flow_table_macros.svh"
module sft_back #(
  parameter int TinCount = sft_pkg::TIN_COUNT
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  sft_pkg::cfg_t    cfg_i,
  output logic             init_done_o,
  input  logic             q_empty_i,
  input  sft_pkg::job_t    q_data_i,
  output logic             q_pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output sft_pkg::result_t out_o
);
  import sft_pkg::*;

  typedef enum logic [11:0] {
    B_CLEAR   = 12'b0000_0000_0001,
    B_IDLE    = 12'b0000_0000_0010,
    B_SCAN    = 12'b0000_0000_0100,
    B_DECIDE  = 12'b0000_0000_1000,
    B_DEB_RD  = 12'b0000_0001_0000,
    B_DEB_UPD = 12'b0000_0010_0000,
    B_REL_RD  = 12'b0000_0100_0000,
    B_REL_WR  = 12'b0000_1000_0000,
    B_TAKE_RD = 12'b0001_0000_0000,
    B_TAKE_WR = 12'b0010_0000_0000,
    B_DIV     = 12'b0100_0000_0000,
    B_DONE    = 12'b1000_0000_0000
  } bstate_e;

  bstate_e           state_q, state_d;
  logic [SLOT_W-1:0] clr_q;
  job_t              job_q;
  logic [WAY_W:0]    scan_q;
  logic              hit_q, free_q;
  logic [WAY_W-1:0]  hit_way_q, free_way_q, least_way_q;
  slot_rec_t         hit_rec_q, least_rec_q;
  logic [SLOT_W-1:0] rel_src_q, rel_dst_q;
  logic [Q_W-1:0]    quo_q;
  logic [REF_W-1:0]  rem_q, dvs_q;
  logic [3:0]        div_cnt_q;
  result_t           res_q, out_q;
  logic              out_valid_q;
  logic [BL_W-1:0]   tin_bytes_q [TIN_COUNT];

  slot_rec_t         slot_mem [FLOW_SLOTS];
  slot_rec_t         sm_rd_q, sm_wd;
  logic              sm_we;
  logic [SLOT_W-1:0] sm_wa, sm_ra;
  logic [REF_W-1:0]  src_ref_mem [FLOW_SLOTS];
  logic [REF_W-1:0]  dst_ref_mem [FLOW_SLOTS];
  logic [REF_W-1:0]  src_rd_q, dst_rd_q, src_wd, dst_wd;
  logic              ref_we;
  logic [SLOT_W-1:0] src_wa, dst_wa, src_ra, dst_ra;

  logic [SLOT_W-1:0] set_base, dec_slot;
  logic [WAY_W-1:0]  dec_way, proc_way;
  logic [BL_W-1:0]   enq_tin_new, hit_bl_new, deb_bl, deb_tin_new;
  logic [TIN_W-1:0]  deb_tin;
  logic              deb_drain;
  slot_rec_t         take_rec, hit_upd_rec, deb_rec;
  logic [REF_W-1:0]  src_inc, dst_inc, src_dec, dst_dec, load;
  logic [Q_W-1:0]    quant_min;
  logic [REF_W:0]    rem_s, rem_n;
  logic              div_ge;
  logic [Q_W-1:0]    quo_n;
  logic              out_load, iso_on;

  assign init_done_o = (state_q != B_CLEAR);
  assign q_pop_o     = (state_q == B_IDLE) && !q_empty_i;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;
  assign out_load    = (state_q == B_DONE) && (!out_valid_q || out_ready_i);
  assign iso_on      = (cfg_i.iso_mode != ISO_NONE);

  assign set_base = {job_q.key[SLOT_W-1:WAY_W], {WAY_W{1'b0}}};
  assign proc_way = scan_q[WAY_W-1:0] - WAY_W'(1);
  assign dec_way  = hit_q ? hit_way_q : (free_q ? free_way_q : least_way_q);
  assign dec_slot = set_base | {{(SLOT_W-WAY_W){1'b0}}, dec_way};

  assign enq_tin_new = sat_add(tin_bytes_q[job_q.tin], job_q.bytes);
  assign hit_bl_new  = sat_add(hit_rec_q.backlog, job_q.bytes);
  assign deb_tin     = (int'(sm_rd_q.tin) >= TinCount) ? '0 : sm_rd_q.tin;
  assign deb_bl      = sat_sub(sm_rd_q.backlog, job_q.bytes);
  assign deb_tin_new = sat_sub(tin_bytes_q[deb_tin], job_q.bytes);
  assign deb_drain   = sm_rd_q.active && (deb_bl == '0);

  always_comb begin
    take_rec          = '0;
    take_rec.active   = 1'b1;
    take_rec.key      = job_q.key;
    take_rec.backlog  = {{(BL_W-BYTES_W){1'b0}}, job_q.bytes};
    take_rec.tin      = job_q.tin;
    take_rec.src_host = job_q.src_host;
    take_rec.dst_host = job_q.dst_host;
    hit_upd_rec         = hit_rec_q;
    hit_upd_rec.backlog = hit_bl_new;
    deb_rec         = sm_rd_q;
    deb_rec.backlog = deb_bl;
    deb_rec.active  = !deb_drain;
  end

  // refcount arithmetic, saturating both ways
  assign src_inc = (src_rd_q == REF_MAX) ? src_rd_q : src_rd_q + REF_W'(1);
  assign dst_inc = (dst_rd_q == REF_MAX) ? dst_rd_q : dst_rd_q + REF_W'(1);
  assign src_dec = (src_rd_q == '0) ? src_rd_q : src_rd_q - REF_W'(1);
  assign dst_dec = (dst_rd_q == '0) ? dst_rd_q : dst_rd_q - REF_W'(1);

  always_comb begin
    unique case (cfg_i.iso_mode)
      ISO_SRC:  load = src_inc;
      ISO_DST:  load = dst_inc;
      ISO_BOTH: load = (src_inc > dst_inc) ? src_inc : dst_inc;
      default:  load = src_inc;
    endcase
    if (load == '0) load = REF_W'(1);
  end

  assign quant_min = (cfg_i.base_quantum == '0) ? Q_W'(1) : cfg_i.base_quantum;

  // restoring divider, one quotient bit a cycle
  assign rem_s  = {rem_q, quo_q[Q_W-1]};
  assign div_ge = (rem_s >= {1'b0, dvs_q});
  assign rem_n  = div_ge ? rem_s - {1'b0, dvs_q} : rem_s;
  assign quo_n  = {quo_q[Q_W-2:0], div_ge};

  always_comb begin
    sm_we  = 1'b0;
    sm_wa  = dec_slot;
    sm_wd  = take_rec;
    sm_ra  = set_base | {{(SLOT_W-WAY_W){1'b0}}, scan_q[WAY_W-1:0]};
    ref_we = 1'b0;
    src_wa = job_q.src_host;
    dst_wa = job_q.dst_host;
    src_wd = src_inc;
    dst_wd = dst_inc;
    src_ra = job_q.src_host;
    dst_ra = job_q.dst_host;
    unique case (state_q)
      B_CLEAR: begin
        sm_we  = 1'b1;
        sm_wa  = clr_q;
        sm_wd  = '0;
        ref_we = 1'b1;
        src_wa = clr_q;
        dst_wa = clr_q;
        src_wd = '0;
        dst_wd = '0;
      end
      B_DECIDE: begin
        sm_we = 1'b1;
        if (hit_q) sm_wd = hit_upd_rec;
      end
      B_DEB_RD: sm_ra = job_q.slot_in;
      B_DEB_UPD: begin
        sm_we = sm_rd_q.active;
        sm_wa = job_q.slot_in;
        sm_wd = deb_rec;
      end
      B_REL_RD: begin
        src_ra = rel_src_q;
        dst_ra = rel_dst_q;
      end
      B_REL_WR: begin
        ref_we = 1'b1;
        src_wa = rel_src_q;
        dst_wa = rel_dst_q;
        src_wd = src_dec;
        dst_wd = dst_dec;
      end
      B_TAKE_WR: ref_we = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (sm_we) slot_mem[sm_wa] <= sm_wd;
    sm_rd_q <= slot_mem[sm_ra];
  end

  always_ff @(posedge clk_i) begin
    if (ref_we) begin
      src_ref_mem[src_wa] <= src_wd;
      dst_ref_mem[dst_wa] <= dst_wd;
    end
    src_rd_q <= src_ref_mem[src_ra];
    dst_rd_q <= dst_ref_mem[dst_ra];
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      B_CLEAR:  if (clr_q == '1) state_d = B_IDLE;
      B_IDLE: begin
        if (!q_empty_i) state_d = (q_data_i.cmd == CMD_ENQ) ? B_SCAN : B_DEB_RD;
      end
      B_SCAN:   if (scan_q == (WAY_W+1)'(SET_WAYS)) state_d = B_DECIDE;
      B_DECIDE: begin
        priority if (hit_q || !iso_on) state_d = B_DONE;
        else if (free_q) state_d = B_TAKE_RD;
        else state_d = B_REL_RD;
      end
      B_DEB_RD:  state_d = B_DEB_UPD;
      B_DEB_UPD: state_d = (deb_drain && iso_on) ? B_REL_RD : B_DONE;
      B_REL_RD:  state_d = B_REL_WR;
      B_REL_WR:  state_d = (job_q.cmd == CMD_ENQ) ? B_TAKE_RD : B_DONE;
      B_TAKE_RD: state_d = B_TAKE_WR;
      B_TAKE_WR: state_d = B_DIV;
      B_DIV:     if (div_cnt_q == 4'd15) state_d = B_DONE;
      B_DONE:    if (out_load) state_d = B_IDLE;
      default:   state_d = B_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < TIN_COUNT; i++) tin_bytes_q[i] <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == B_CLEAR) clr_q <= clr_q + SLOT_W'(1);
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (state_q == B_DECIDE) tin_bytes_q[job_q.tin] <= enq_tin_new;
      if (state_q == B_DEB_UPD && sm_rd_q.active) tin_bytes_q[deb_tin] <= deb_tin_new;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) out_q <= res_q;
    unique case (state_q)
      B_IDLE: begin
        job_q  <= q_data_i;
        scan_q <= '0;
        hit_q  <= 1'b0;
        free_q <= 1'b0;
      end
      B_SCAN: begin
        scan_q <= scan_q + (WAY_W+1)'(1);
        if (scan_q != '0) begin
          if (!hit_q && sm_rd_q.active && sm_rd_q.key == job_q.key) begin
            hit_q     <= 1'b1;
            hit_way_q <= proc_way;
            hit_rec_q <= sm_rd_q;
          end
          if (!free_q && !sm_rd_q.active) begin
            free_q     <= 1'b1;
            free_way_q <= proc_way;
          end
          // first way with the strictly smallest backlog
          if (proc_way == '0 || sm_rd_q.backlog < least_rec_q.backlog) begin
            least_way_q <= proc_way;
            least_rec_q <= sm_rd_q;
          end
        end
      end
      B_DECIDE: begin
        res_q.slot          <= dec_slot;
        res_q.new_flow      <= !hit_q;
        res_q.evicted       <= !hit_q && !free_q;
        res_q.start_deficit <= hit_q ? '0 : quant_min;
        res_q.flow_empty    <= 1'b0;
        res_q.flow_backlog  <= hit_q ? hit_bl_new : take_rec.backlog;
        res_q.tin_backlog   <= enq_tin_new;
        rel_src_q           <= least_rec_q.src_host;
        rel_dst_q           <= least_rec_q.dst_host;
      end
      B_DEB_UPD: begin
        res_q.slot          <= job_q.slot_in;
        res_q.new_flow      <= 1'b0;
        res_q.evicted       <= 1'b0;
        res_q.start_deficit <= '0;
        res_q.flow_empty    <= deb_drain;
        res_q.flow_backlog  <= sm_rd_q.active ? deb_bl : sm_rd_q.backlog;
        res_q.tin_backlog   <= sm_rd_q.active ? deb_tin_new : tin_bytes_q[deb_tin];
        rel_src_q           <= sm_rd_q.src_host;
        rel_dst_q           <= sm_rd_q.dst_host;
      end
      B_TAKE_WR: begin
        dvs_q     <= load;
        quo_q     <= cfg_i.base_quantum;
        rem_q     <= '0;
        div_cnt_q <= '0;
      end
      B_DIV: begin
        quo_q     <= quo_n;
        rem_q     <= rem_n[REF_W-1:0];
        div_cnt_q <= div_cnt_q + 4'd1;
        if (div_cnt_q == 4'd15) res_q.start_deficit <= (quo_n == '0) ? Q_W'(1) : quo_n;
      end
      default: ;
    endcase
  end

  `SFT_ASSERT_IMPL(a_no_pop_in_clear, state_q == B_CLEAR, !q_pop_o, "item taken during clear")
  `SFT_ASSERT_IMPL(a_divisor_nonzero, state_q == B_DIV, dvs_q != '0, "zero divisor")
  `SFT_ASSERT_IMPL(a_evict_is_new, out_valid_q && out_q.evicted, out_q.new_flow, "evict without new flow")
  `SFT_ASSERT_IMPL(a_empty_zero, out_valid_q && out_q.flow_empty, out_q.flow_backlog == '0, "released flow has backlog")
  `SFT_ASSERT_NEXT(a_load_shows, out_load, out_valid_q, "result not presented")

endmodule

>>> hdl/set_assoc_flow_table.sv
// top level of the set-associative flow table: config registers and channel wiring
//
//  channel     | dir | handshake                   | beat holds
//  s_axis      | in  | s_axis_tvalid/s_axis_tready | enqueue or debit item
//  m_axis      | out | m_axis_tvalid/m_axis_tready | one result per item
//  apb         | in  | psel/penable/pready         | hash_seed, isolation_mode, base_quantum
//
// an enqueue scans the 8 ways of its set through the one read port of the slot memory;
// with isolation on a new flow adds refcount read-modify-writes and a quantum divide. a
// debit reads and writes its slot, releasing refcounts if it drains with isolation on. the
// front end runs ahead through a 2-entry queue. after reset a pass clears the slot
// and refcount memories with s_axis_tready low. a stalled m_axis holds the back end.
module set_assoc_flow_table #(
  parameter int TinCount = sft_pkg::TIN_COUNT
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // flow_hash[9:0], tin[11:10], pkt_bytes[27:12], slot_in[37:28], zero pad
  input  logic [sft_pkg::S_TDATA_W-1:0] s_axis_tdata,
  // cmd
  input  logic                          s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // slot[9:0], new_flow[10], evicted[11], start_deficit[27:12], flow_empty[28],
  // flow_backlog[60:29], tin_backlog[92:61], zero pad
  output logic [sft_pkg::M_TDATA_W-1:0] m_axis_tdata,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [sft_pkg::PADDR_W-1:0]   paddr,
  input  logic [sft_pkg::PDATA_W-1:0]   pwdata,
  output logic [sft_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);
  import sft_pkg::*;

  logic [SEED_W-1:0] hash_seed_q;
  logic [1:0]        iso_mode_q;
  logic [Q_W-1:0]    base_quantum_q;
  cfg_t              cfg;
  logic              cfg_wr, init_done, q_full, q_empty, q_push, q_pop;
  job_t              q_in, q_out;
  result_t           res;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_seed_q    <= '0;
      iso_mode_q     <= ISO_NONE;
      base_quantum_q <= QUANTUM_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_HASH_SEED:    hash_seed_q    <= pwdata;
        REG_ISO_MODE:     iso_mode_q     <= pwdata[1:0];
        REG_BASE_QUANTUM: base_quantum_q <= pwdata[Q_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_HASH_SEED:    prdata = hash_seed_q;
      REG_ISO_MODE:     prdata = {{(PDATA_W-2){1'b0}}, iso_mode_q};
      REG_BASE_QUANTUM: prdata = {{(PDATA_W-Q_W){1'b0}}, base_quantum_q};
      default:          prdata = '0;
    endcase
  end

  assign cfg.hash_seed    = hash_seed_q;
  assign cfg.iso_mode     = iso_mode_q;
  assign cfg.base_quantum = base_quantum_q;

  sft_front #(.TinCount(TinCount)) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .hash_seed_i   (hash_seed_q),
    .init_done_i   (init_done),
    .q_full_i      (q_full),
    .q_push_o      (q_push),
    .q_data_o      (q_in)
  );

  sft_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .data_o  (q_out)
  );

  sft_back #(.TinCount(TinCount)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .init_done_o (init_done),
    .q_empty_i   (q_empty),
    .q_data_i    (q_out),
    .q_pop_o     (q_pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_o       (res)
  );

  assign m_axis_tdata = {3'b000, res.tin_backlog, res.flow_backlog, res.flow_empty,
                         res.start_deficit, res.evicted, res.new_flow, res.slot};

endmodule
